@@ src/sha1md_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 digest block.
`timescale 1ns / 1ps
package sha1md_pkg;

    typedef logic [31:0] t_word;
    typedef logic [1:0]  t_byte_src;
    typedef logic [1:0]  t_phase;

    localparam int NUM_WORDS = 5;

    localparam t_byte_src SRC_MSG  = 2'd0;
    localparam t_byte_src SRC_80   = 2'd1;
    localparam t_byte_src SRC_ZERO = 2'd2;
    localparam t_byte_src SRC_LEN  = 2'd3;

    localparam t_phase PH_CH  = 2'd0;
    localparam t_phase PH_P1  = 2'd1;
    localparam t_phase PH_MAJ = 2'd2;
    localparam t_phase PH_P3  = 2'd3;

    localparam logic [5:0] POS_LAST   = 6'd63;
    localparam logic [5:0] POS_LENGTH = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_P1   = 7'd20;
    localparam logic [6:0] ROUND_MAJ  = 7'd40;
    localparam logic [6:0] ROUND_P3   = 7'd60;
    localparam logic [2:0] LEN_LAST   = 3'd7;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam t_word INIT_H [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct packed {
        logic      absorb;
        t_byte_src src;
        logic      load_work;
        logic      round;
        t_phase    phase;
        logic      add;
        logic      finish;
        logic [2:0] word_sel;
    } t_dp_cmd;

    function automatic t_word round_f(input t_phase ph, input t_word b, input t_word c,
                                      input t_word d);
        t_word f;
        unique case (ph)
            PH_CH:   f = (b & c) | (~b & d);
            PH_MAJ:  f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic t_word round_k(input t_phase ph);
        t_word k;
        unique case (ph)
            PH_CH:   k = 32'h5A827999;
            PH_P1:   k = 32'h6ED9EBA1;
            PH_MAJ:  k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

endpackage

@@ src/sha1md_if.sv @@
// Valid/ready stream interfaces for the byte input and the digest output.
`timescale 1ns / 1ps
interface sha1md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output has_byte, output last_byte,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input last_byte,
                  output ready);
endinterface

interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

@@ src/sha1md_ctrl.sv @@
// Controller: byte fill, padding, round sequencing and digest output.
`timescale 1ns / 1ps
module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_has_byte,
    input  logic    i_last_byte,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD80 = 3'd1;
    localparam logic [2:0] S_PADZ  = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;
    logic [5:0] r_pos, n_pos;
    logic [6:0] r_round, n_round;
    logic [2:0] r_len_cnt, n_len_cnt;
    logic [2:0] r_idx, n_idx;
    logic [5:0] pos_inc;
    logic [2:0] follow;
    logic       blk_end;

    assign pos_inc = r_pos + 6'd1;
    assign blk_end = (r_pos == POS_LAST);

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_pos     = r_pos;
        n_round   = r_round;
        n_len_cnt = r_len_cnt;
        n_idx     = r_idx;
        follow    = S_IDLE;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd = '0;
        o_cmd.word_sel = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    follow = i_last_byte ? S_PAD80 : S_IDLE;
                    if (i_has_byte) begin
                        o_cmd.absorb = 1'b1;
                        o_cmd.src    = SRC_MSG;
                        n_pos        = pos_inc;
                    end
                    if (i_has_byte && blk_end) begin
                        o_cmd.load_work = 1'b1;
                        n_ret   = follow;
                        n_state = S_ROUND;
                    end else begin
                        n_state = follow;
                    end
                end
            end
            S_PAD80, S_PADZ: begin
                o_cmd.absorb = 1'b1;
                o_cmd.src    = (r_state == S_PAD80) ? SRC_80 : SRC_ZERO;
                n_pos        = pos_inc;
                follow       = (pos_inc == POS_LENGTH) ? S_LEN : S_PADZ;
                if (blk_end) begin
                    o_cmd.load_work = 1'b1;
                    n_ret   = follow;
                    n_state = S_ROUND;
                end else begin
                    n_state = follow;
                end
            end
            S_LEN: begin
                o_cmd.absorb = 1'b1;
                o_cmd.src    = SRC_LEN;
                n_pos        = pos_inc;
                n_len_cnt    = r_len_cnt + 3'd1;
                follow       = (r_len_cnt == LEN_LAST) ? S_EMIT : S_LEN;
                if (blk_end) begin
                    o_cmd.load_work = 1'b1;
                    n_ret   = follow;
                    n_state = S_ROUND;
                end else begin
                    n_state = follow;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                priority if (r_round < ROUND_P1) begin
                    o_cmd.phase = PH_CH;
                end else if (r_round < ROUND_MAJ) begin
                    o_cmd.phase = PH_P1;
                end else if (r_round < ROUND_P3) begin
                    o_cmd.phase = PH_MAJ;
                end else begin
                    o_cmd.phase = PH_P3;
                end
                if (r_round == ROUND_LAST) begin
                    n_round = '0;
                    n_state = S_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = r_ret;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_idx == WORD_LAST) begin
                        o_cmd.finish = 1'b1;
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_pos     <= '0;
            r_round   <= '0;
            r_len_cnt <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_pos     <= n_pos;
            r_round   <= n_round;
            r_len_cnt <= n_len_cnt;
            r_idx     <= n_idx;
        end
    end

endmodule

@@ src/sha1md_dp.sv @@
// Datapath: block shift register, message schedule, round logic, chaining words.
`timescale 1ns / 1ps
module sha1md_dp
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_data_byte,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic [511:0] r_blk;
    t_word        r_h [NUM_WORDS];
    t_word        r_a, r_b, r_c, r_d, r_e;
    logic [63:0]  r_bits;
    logic [7:0]   byte_in;
    t_word        w_cur, w_x, w_new, t_sum;

    always_comb begin
        unique case (i_cmd.src)
            SRC_MSG:  byte_in = i_data_byte;
            SRC_80:   byte_in = PAD_BYTE;
            SRC_ZERO: byte_in = 8'h00;
            default:  byte_in = r_bits[63:56];
        endcase
    end

    assign w_cur = r_blk[511:480];
    assign w_x   = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ w_cur;
    assign w_new = {w_x[30:0], w_x[31]};
    assign t_sum = {r_a[26:0], r_a[31:27]} + round_f(i_cmd.phase, r_b, r_c, r_d)
                   + r_e + round_k(i_cmd.phase) + w_cur;

    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            r_blk <= {r_blk[503:0], byte_in};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_h[i] <= INIT_H[i];
            end
            r_bits <= '0;
        end else begin
            if (i_cmd.add) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.absorb && i_cmd.src == SRC_MSG) begin
                r_bits <= r_bits + 64'd8;
            end else if (i_cmd.absorb && i_cmd.src == SRC_LEN) begin
                r_bits <= {r_bits[55:0], 8'h00};
            end
        end
    end

    assign o_digest_word = (i_cmd.word_sel <= WORD_LAST) ? r_h[i_cmd.word_sel] : r_h[0];
    assign o_word_index  = i_cmd.word_sel;
    assign o_last_word   = (i_cmd.word_sel == WORD_LAST);

endmodule

@@ src/sha1_message_digest.sv @@
// Top level of the SHA-1 message digest block.
`timescale 1ns / 1ps
// SHA-1 over a byte stream. Each input transfer carries at most one message byte and
// may end the message. Every 64th byte starts a compression (80 rounds on a single
// round unit plus the chaining add), during which input is held off. On the end of a
// message the block appends padding and the 64-bit bit length (9 to 72 bytes) one
// byte per cycle while no compression runs, runs one or two compressions, then
// presents the five digest words, h0 first, one per output transfer, and returns
// to the initial hash values. No input is taken while digest words wait.
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    sha1md_in_if.sink          i_in,
    sha1md_out_if.source       o_out
);

    t_dp_cmd cmd;

    sha1md_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_has_byte  (i_in.has_byte),
        .i_last_byte (i_in.last_byte),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    sha1md_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_in.data_byte),
        .o_digest_word (o_out.digest_word),
        .o_word_index  (o_out.word_index),
        .o_last_word   (o_out.last_word)
    );

endmodule

@@ src/sha1md_checker.sv @@
// Port-level checks for the SHA-1 digest block and their binding.
`timescale 1ns / 1ps
module sha1md_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_word_index,
    input logic       i_last_word
);

    logic out_xfer;

    assign out_xfer = i_out_valid && i_out_ready;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while digest words pending");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_word == (i_word_index == 3'd4)))
        else $error("last_word does not match word_index");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !i_last_word) |=>
            (i_out_valid && i_word_index == $past(i_word_index) + 3'd1))
        else $error("digest words out of order");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && i_last_word) |=> (i_in_ready && !i_out_valid))
        else $error("no return to idle after last digest word");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_word_index (o_out.word_index),
    .i_last_word  (o_out.last_word)
);

@@ verif/tb_sha1_message_digest.sv @@
// Self-checking testbench for the SHA-1 byte-stream digest block.
`timescale 1ns / 1ps
module tb_sha1_message_digest;

    localparam int          RUN_LIMIT   = 250000;
    localparam int          HOLD_LEN    = 300;
    localparam int          SETTLE_LEN  = 200;
    localparam int          NUM_OUT     = 5;
    localparam logic [2:0]  LAST_IDX    = 3'd4;
    localparam logic [5:0]  BLOCK_END   = 6'd63;
    localparam logic [5:0]  LEN_POS     = 6'd56;
    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam logic [31:0] K_CH        = 32'h5A827999;
    localparam logic [31:0] K_PAR1      = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ       = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR3      = 32'hCA62C1D6;
    localparam logic [31:0] H_INIT [NUM_OUT] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [159:0] EMPTY_DIGEST =
        160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_out;

    typedef struct packed {
        logic [7:0]   data;
        logic         has;
        logic         last;
        logic         known;
        logic [159:0] digest;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sha1md_in_if  in_if ();
    sha1md_out_if out_if ();

    sha1_message_digest u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [31:0]  sha_chain [NUM_OUT];
    logic [7:0]   sha_block [64];
    logic [63:0]  sha_bits;
    t_digest_out  digest_q [$];
    t_stim_row    stim_table [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_request;
    int  hold_left;
    int  error_count;
    int  words_checked;
    int  msg_count;
    int  byte_count;
    int  item_count;
    int  longest_msg;
    int  cycle_count;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {sha_block[4*i], sha_block[4*i+1], sha_block[4*i+2], sha_block[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = sha_chain[0];
        b = sha_chain[1];
        c = sha_chain[2];
        d = sha_chain[3];
        e = sha_chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PAR3;
            end
            t = rotl32(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        sha_chain[0] += a;
        sha_chain[1] += b;
        sha_chain[2] += c;
        sha_chain[3] += d;
        sha_chain[4] += e;
    endfunction

    function automatic void sha_absorb(input logic [7:0] value);
        logic [5:0] pos;
        pos = sha_bits[8:3];
        sha_block[pos] = value;
        sha_bits = sha_bits + 64'd8;
        if (pos == BLOCK_END)
            sha_compress();
    endfunction

    // Return the number of digest words this transfer produces.
    function automatic int predict_digest(input logic [7:0] value, input logic has,
                                          input logic last,
                                          output t_digest_out res [NUM_OUT]);
        logic [63:0] msg_bits;
        if (has)
            sha_absorb(value);
        if (!last)
            return 0;
        msg_bits = sha_bits;
        sha_absorb(PAD_MARK);
        while (sha_bits[8:3] != LEN_POS)
            sha_absorb(8'h00);
        for (int i = 0; i < 8; i++)
            sha_absorb(msg_bits[63 - 8*i -: 8]);
        for (int i = 0; i < NUM_OUT; i++) begin
            res[i].word = sha_chain[i];
            res[i].idx  = i[2:0];
            res[i].last = (i[2:0] == LAST_IDX);
        end
        sha_chain = H_INIT;
        sha_bits  = '0;
        return NUM_OUT;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct  = 86;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 86;
            end
            default: begin
                send_idle_pct  = 23;
                recv_stall_pct = 23;
            end
        endcase
    endtask

    task automatic add_row(input logic [7:0] data, input logic has, input logic last,
                           input logic known, input logic [159:0] digest);
        t_stim_row row;
        row = '{data, has, last, known, digest};
        stim_table.push_back(row);
    endtask

    // Call right after a rising edge; returns at the edge of the transfer.
    task automatic send_item(input logic [7:0] value, input logic has, input logic last,
                             input logic known, input logic [159:0] digest);
        t_digest_out res [NUM_OUT];
        int          n;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= has ? value : 8'($urandom_range(255));
        in_if.has_byte  <= has;
        in_if.last_byte <= last;
        do @(posedge i_clk); while (!in_if.ready);
        n = predict_digest(value, has, last, res);
        for (int i = 0; i < n; i++) begin
            if (known) begin
                res[i].word = digest[159 - 32*i -: 32];
            end
            digest_q.push_back(res[i]);
        end
        item_count++;
        if (has)
            byte_count++;
        if (last)
            msg_count++;
    endtask

    // Random bytes of the given length, sprinkled with ignored transfers.
    task automatic send_message(input int len);
        bit split_end;
        split_end = (len == 0) || ($urandom_range(3) == 0);
        if (len > longest_msg)
            longest_msg = len;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
                send_item(8'h00, 1'b0, 1'b0, 1'b0, '0);
            send_item(8'($urandom_range(255)), 1'b1, !split_end && (i == len - 1),
                      1'b0, '0);
        end
        if (split_end)
            send_item(8'h00, 1'b0, 1'b1, 1'b0, '0);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_request) begin
            out_if.ready <= 1'b0;
            hold_left    <= HOLD_LEN;
            hold_request  = 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_digest_out want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (digest_q.size() == 0) begin
                report_error($sformatf("unexpected digest word %h index %0d",
                                       out_if.digest_word, out_if.word_index));
            end else begin
                want = digest_q.pop_front();
                if (out_if.digest_word !== want.word)
                    report_error($sformatf("digest_word %h, want %h (index %0d)",
                                           out_if.digest_word, want.word, want.idx));
                if (out_if.word_index !== want.idx)
                    report_error($sformatf("word_index %0d, want %0d",
                                           out_if.word_index, want.idx));
                if (out_if.last_word !== want.last)
                    report_error($sformatf("last_word %b, want %b (index %0d)",
                                           out_if.last_word, want.last, want.idx));
                words_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, digest_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int len;
        int sel;
        int rand_msgs;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.has_byte  = 1'b0;
        in_if.last_byte = 1'b0;
        out_if.ready    = 1'b0;
        hold_request    = 1'b0;
        hold_left       = 0;
        error_count     = 0;
        words_checked   = 0;
        msg_count       = 0;
        byte_count      = 0;
        item_count      = 0;
        longest_msg     = 3;
        cycle_count     = 0;
        rand_msgs       = 0;
        sha_chain       = H_INIT;
        sha_bits        = '0;
        for (int i = 0; i < 64; i++)
            sha_block[i] = 8'h00;
        set_idle_mode(IDLE_NONE);

        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);
        add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h63, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);
        add_row(8'hFF, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h55, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'hAA, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[i])
            send_item(stim_table[i].data, stim_table[i].has, stim_table[i].last,
                      stim_table[i].known, stim_table[i].digest);
        wait_drained();

        // Padding fits in one block, then spills into a second.
        set_idle_mode(IDLE_NONE);
        send_message(55);
        set_idle_mode(IDLE_BOTH);
        send_message(56);
        wait_drained();

        // Hold the output while input keeps coming.
        set_idle_mode(IDLE_NONE);
        @(posedge i_clk);
        hold_request = 1'b1;
        send_message(3);
        send_message(0);
        send_message(2);
        wait_drained();

        while (item_count < 230 || rand_msgs < 4) begin
            set_idle_mode(t_idle_mode'(rand_msgs % 4));
            sel = $urandom_range(11);
            if (sel < 8)
                len = $urandom_range(12);
            else if (sel < 11)
                len = $urandom_range(40, 13);
            else
                len = $urandom_range(70, 57);
            send_message(len);
            rand_msgs++;
            if ($urandom_range(7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_LEN) @(posedge i_clk);

        $display("run covered %0d messages of up to %0d bytes (%0d bytes total)",
                 msg_count, longest_msg, byte_count);
        $display("%0d digest words compared under four idle mixes, %0d errors",
                 words_checked, error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
